[src/tlsch_pkg.sv]
`default_nettype none
package tlsch_pkg;

   localparam logic [5:0]  RandomLen    = 6'd32;
   localparam logic [15:0] ExtServerName = 16'h0000;
   localparam logic [15:0] ExtAlpn       = 16'h0010;
   localparam logic [15:0] ExtSupVers    = 16'h002B;

   typedef enum logic [3:0] {
      TK_VERSION     = 4'd0,
      TK_SID_LEN     = 4'd1,
      TK_SID_BYTE    = 4'd2,
      TK_SUITE       = 4'd3,
      TK_EXT_TYPE    = 4'd4,
      TK_SNI_LEN     = 4'd5,
      TK_SNI_BYTE    = 4'd6,
      TK_ALPN_LEN    = 4'd7,
      TK_ALPN_BYTE   = 4'd8,
      TK_SUP_VERSION = 4'd9,
      TK_DONE        = 4'd10,
      TK_ERROR       = 4'd11
   } token_kind_type;

   typedef enum logic [1:0] {
      CAUSE_NONE  = 2'd0,
      CAUSE_TRUNC = 2'd1,
      CAUSE_ODD   = 2'd2,
      CAUSE_OVER  = 2'd3
   } cause_type;

   typedef enum logic [1:0] {
      CLS_OTHER = 2'd0,
      CLS_SNI   = 2'd1,
      CLS_ALPN  = 2'd2,
      CLS_SV    = 2'd3
   } ext_class_type;

   typedef enum logic [4:0] {
      PH_VER_HI, PH_VER_LO, PH_RANDOM, PH_SID_LEN, PH_SID_BYTE,
      PH_CS_LEN_HI, PH_CS_LEN_LO, PH_CS_HI, PH_CS_LO, PH_COMP_LEN, PH_COMP_SKIP,
      PH_EXT_LEN_HI, PH_EXT_LEN_LO, PH_EXT_T_HI, PH_EXT_T_LO, PH_EXT_L_HI,
      PH_EXT_L_LO, PH_TRAIL,
      PH_EXT_SKIP, PH_LIST_HI, PH_LIST_LO, PH_SNI_NTYPE, PH_SNI_NLEN_HI,
      PH_SNI_NLEN_LO, PH_SNI_NAME, PH_SNI_OTHER, PH_ALPN_PLEN, PH_ALPN_PBYTE,
      PH_SV_LEN, PH_SV_HI, PH_SV_LO
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [3:0]  token_kind;
      logic [15:0] token_value;
      logic [1:0]  error_cause;
      logic        run_last;
   } rsp_type;

   // Up to two result beats that one input beat produces.
   typedef struct packed {
      logic    [1:0] count;
      rsp_type       first;
      rsp_type       second;
   } burst_type;

   function automatic logic [15:0] dec16(input logic [15:0] v);
      dec16 = (v != 16'd0) ? v - 16'd1 : 16'd0;
   endfunction

endpackage
`default_nettype wire

[src/tlsch_parser.sv]
`default_nettype none
module tlsch_parser (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     step,
   input  tlsch_pkg::req_type      item,
   output tlsch_pkg::burst_type    burst
);

   tlsch_pkg::phase_type      phase_ff, phase_in;
   logic [5:0]                prefix_ff, prefix_in;
   logic [15:0]               field_ff, field_in;
   logic [15:0]               exts_ff, exts_in;
   logic [15:0]               ext_ff, ext_in;
   logic [15:0]               list_ff, list_in;
   logic [7:0]                held_ff, held_in;
   tlsch_pkg::ext_class_type  cls_ff, cls_in;
   logic                      failed_ff, failed_in;

   logic [7:0]  b;
   logic [15:0] word;
   logic        in_ext;
   logic [1:0]  err;
   logic        tok_v;
   tlsch_pkg::token_kind_type tok_k;
   logic [15:0] tok_val;
   logic        end_v;
   tlsch_pkg::rsp_type end_r;
   logic        do_reset;
   logic [15:0] list_dec;
   logic [15:0] cs_rem;

   assign b    = item.data_byte;
   assign word = {held_ff, item.data_byte};

   always_comb begin
      phase_in  = phase_ff;
      prefix_in = prefix_ff;
      field_in  = field_ff;
      exts_in   = exts_ff;
      ext_in    = ext_ff;
      list_in   = list_ff;
      held_in   = held_ff;
      cls_in    = cls_ff;
      failed_in = failed_ff;
      err       = tlsch_pkg::CAUSE_NONE;
      tok_v     = 1'b0;
      tok_k     = tlsch_pkg::TK_VERSION;
      tok_val   = 16'd0;
      end_v     = 1'b0;
      end_r     = '0;
      do_reset  = 1'b0;
      in_ext    = phase_ff >= tlsch_pkg::PH_EXT_SKIP;
      list_dec  = tlsch_pkg::dec16(list_ff);
      cs_rem    = (field_ff >= 16'd2) ? field_ff - 16'd2 : 16'd0;

      if (failed_ff) begin
         do_reset = item.last_byte;
      end else begin
         if (in_ext) begin
            ext_in  = tlsch_pkg::dec16(ext_ff);
            exts_in = tlsch_pkg::dec16(exts_ff);
         end
         if (phase_ff >= tlsch_pkg::PH_EXT_T_HI && phase_ff <= tlsch_pkg::PH_EXT_L_LO) begin
            exts_in = tlsch_pkg::dec16(exts_ff);
         end

         unique case (phase_ff)
            tlsch_pkg::PH_VER_HI, tlsch_pkg::PH_CS_LEN_HI, tlsch_pkg::PH_CS_HI,
            tlsch_pkg::PH_EXT_LEN_HI, tlsch_pkg::PH_EXT_T_HI, tlsch_pkg::PH_EXT_L_HI,
            tlsch_pkg::PH_LIST_HI, tlsch_pkg::PH_SV_HI: begin
               held_in  = b;
               phase_in = tlsch_pkg::phase_type'(phase_ff + 5'd1);
               if (phase_ff == tlsch_pkg::PH_SV_HI) begin
                  list_in = list_dec;
               end
            end
            tlsch_pkg::PH_VER_LO: begin
               tok_v = 1'b1; tok_k = tlsch_pkg::TK_VERSION; tok_val = word;
               prefix_in = 6'd0;
               phase_in  = tlsch_pkg::PH_RANDOM;
            end
            tlsch_pkg::PH_RANDOM: begin
               prefix_in = prefix_ff + 6'd1;
               if (prefix_in >= tlsch_pkg::RandomLen) begin
                  phase_in = tlsch_pkg::PH_SID_LEN;
               end
            end
            tlsch_pkg::PH_SID_LEN: begin
               tok_v = 1'b1; tok_k = tlsch_pkg::TK_SID_LEN; tok_val = {8'd0, b};
               field_in = {8'd0, b};
               phase_in = (b != 8'd0) ? tlsch_pkg::PH_SID_BYTE : tlsch_pkg::PH_CS_LEN_HI;
            end
            tlsch_pkg::PH_SID_BYTE: begin
               tok_v = 1'b1; tok_k = tlsch_pkg::TK_SID_BYTE; tok_val = {8'd0, b};
               field_in = tlsch_pkg::dec16(field_ff);
               if (field_in == 16'd0) begin
                  phase_in = tlsch_pkg::PH_CS_LEN_HI;
               end
            end
            tlsch_pkg::PH_CS_LEN_LO: begin
               if (word[0]) begin
                  err = tlsch_pkg::CAUSE_ODD;
               end else begin
                  field_in = word;
                  phase_in = (word != 16'd0) ? tlsch_pkg::PH_CS_HI : tlsch_pkg::PH_COMP_LEN;
               end
            end
            tlsch_pkg::PH_CS_LO: begin
               tok_v = 1'b1; tok_k = tlsch_pkg::TK_SUITE; tok_val = word;
               field_in = cs_rem;
               phase_in = (cs_rem != 16'd0) ? tlsch_pkg::PH_CS_HI : tlsch_pkg::PH_COMP_LEN;
            end
            tlsch_pkg::PH_COMP_LEN: begin
               field_in = {8'd0, b};
               phase_in = (b != 8'd0) ? tlsch_pkg::PH_COMP_SKIP : tlsch_pkg::PH_EXT_LEN_HI;
            end
            tlsch_pkg::PH_COMP_SKIP: begin
               field_in = tlsch_pkg::dec16(field_ff);
               if (field_in == 16'd0) begin
                  phase_in = tlsch_pkg::PH_EXT_LEN_HI;
               end
            end
            tlsch_pkg::PH_EXT_LEN_LO: begin
               exts_in = word;
               if (word >= 16'd4) begin
                  phase_in = tlsch_pkg::PH_EXT_T_HI;
               end else if (word != 16'd0) begin
                  ext_in   = word;
                  phase_in = tlsch_pkg::PH_EXT_SKIP;
               end else begin
                  phase_in = tlsch_pkg::PH_TRAIL;
               end
            end
            tlsch_pkg::PH_EXT_T_LO: begin
               tok_v = 1'b1; tok_k = tlsch_pkg::TK_EXT_TYPE; tok_val = word;
               if (word == tlsch_pkg::ExtServerName) begin
                  cls_in = tlsch_pkg::CLS_SNI;
               end else if (word == tlsch_pkg::ExtAlpn) begin
                  cls_in = tlsch_pkg::CLS_ALPN;
               end else if (word == tlsch_pkg::ExtSupVers) begin
                  cls_in = tlsch_pkg::CLS_SV;
               end else begin
                  cls_in = tlsch_pkg::CLS_OTHER;
               end
               phase_in = tlsch_pkg::PH_EXT_L_HI;
            end
            tlsch_pkg::PH_EXT_L_LO: begin
               // Compare against the block count already decremented for this beat.
               if (word > exts_in) begin
                  err = tlsch_pkg::CAUSE_OVER;
               end else begin
                  ext_in = word;
                  if (word == 16'd0) begin
                     if (exts_in >= 16'd4) begin
                        phase_in = tlsch_pkg::PH_EXT_T_HI;
                     end else if (exts_in != 16'd0) begin
                        ext_in   = exts_in;
                        phase_in = tlsch_pkg::PH_EXT_SKIP;
                     end else begin
                        phase_in = tlsch_pkg::PH_TRAIL;
                     end
                  end else if (cls_ff == tlsch_pkg::CLS_SV) begin
                     phase_in = tlsch_pkg::PH_SV_LEN;
                  end else if (cls_ff != tlsch_pkg::CLS_OTHER && word >= 16'd2) begin
                     phase_in = tlsch_pkg::PH_LIST_HI;
                  end else begin
                     phase_in = tlsch_pkg::PH_EXT_SKIP;
                  end
               end
            end
            tlsch_pkg::PH_LIST_LO: begin
               if (word > ext_in) begin
                  phase_in = tlsch_pkg::PH_EXT_SKIP;
               end else begin
                  list_in = word;
                  if (cls_ff == tlsch_pkg::CLS_SNI) begin
                     phase_in = (word >= 16'd3) ? tlsch_pkg::PH_SNI_NTYPE
                                                : tlsch_pkg::PH_EXT_SKIP;
                  end else begin
                     phase_in = (word != 16'd0) ? tlsch_pkg::PH_ALPN_PLEN
                                                : tlsch_pkg::PH_EXT_SKIP;
                  end
               end
            end
            tlsch_pkg::PH_SNI_NTYPE: begin
               prefix_in = (b != 8'd0) ? 6'd1 : 6'd0;
               list_in   = list_dec;
               phase_in  = tlsch_pkg::PH_SNI_NLEN_HI;
            end
            tlsch_pkg::PH_SNI_NLEN_HI: begin
               held_in  = b;
               list_in  = list_dec;
               phase_in = tlsch_pkg::PH_SNI_NLEN_LO;
            end
            tlsch_pkg::PH_SNI_NLEN_LO: begin
               list_in  = list_dec;
               field_in = word;
               if (word > list_dec) begin
                  phase_in = tlsch_pkg::PH_EXT_SKIP;
               end else if (prefix_ff == 6'd0) begin
                  tok_v = 1'b1; tok_k = tlsch_pkg::TK_SNI_LEN; tok_val = word;
                  phase_in = (word != 16'd0) ? tlsch_pkg::PH_SNI_NAME : tlsch_pkg::PH_EXT_SKIP;
               end else if (word != 16'd0) begin
                  phase_in = tlsch_pkg::PH_SNI_OTHER;
               end else begin
                  phase_in = (list_dec >= 16'd3) ? tlsch_pkg::PH_SNI_NTYPE
                                                 : tlsch_pkg::PH_EXT_SKIP;
               end
            end
            tlsch_pkg::PH_SNI_NAME: begin
               tok_v = 1'b1; tok_k = tlsch_pkg::TK_SNI_BYTE; tok_val = {8'd0, b};
               field_in = tlsch_pkg::dec16(field_ff);
               if (field_in == 16'd0) begin
                  phase_in = tlsch_pkg::PH_EXT_SKIP;
               end
            end
            tlsch_pkg::PH_SNI_OTHER: begin
               field_in = tlsch_pkg::dec16(field_ff);
               list_in  = list_dec;
               if (field_in == 16'd0) begin
                  phase_in = (list_dec >= 16'd3) ? tlsch_pkg::PH_SNI_NTYPE
                                                 : tlsch_pkg::PH_EXT_SKIP;
               end
            end
            tlsch_pkg::PH_ALPN_PLEN: begin
               list_in = list_dec;
               if ({8'd0, b} > list_dec) begin
                  phase_in = tlsch_pkg::PH_EXT_SKIP;
               end else begin
                  tok_v = 1'b1; tok_k = tlsch_pkg::TK_ALPN_LEN; tok_val = {8'd0, b};
                  field_in = {8'd0, b};
                  if (b != 8'd0) begin
                     phase_in = tlsch_pkg::PH_ALPN_PBYTE;
                  end else begin
                     phase_in = (list_dec != 16'd0) ? tlsch_pkg::PH_ALPN_PLEN
                                                    : tlsch_pkg::PH_EXT_SKIP;
                  end
               end
            end
            tlsch_pkg::PH_ALPN_PBYTE: begin
               tok_v = 1'b1; tok_k = tlsch_pkg::TK_ALPN_BYTE; tok_val = {8'd0, b};
               field_in = tlsch_pkg::dec16(field_ff);
               list_in  = list_dec;
               if (field_in == 16'd0) begin
                  phase_in = (list_dec != 16'd0) ? tlsch_pkg::PH_ALPN_PLEN
                                                 : tlsch_pkg::PH_EXT_SKIP;
               end
            end
            tlsch_pkg::PH_SV_LEN: begin
               if ({8'd0, b} > ext_in || b < 8'd2) begin
                  phase_in = tlsch_pkg::PH_EXT_SKIP;
               end else begin
                  list_in  = {8'd0, b};
                  phase_in = tlsch_pkg::PH_SV_HI;
               end
            end
            tlsch_pkg::PH_SV_LO: begin
               tok_v = 1'b1; tok_k = tlsch_pkg::TK_SUP_VERSION; tok_val = word;
               list_in  = list_dec;
               phase_in = (list_dec >= 16'd2) ? tlsch_pkg::PH_SV_HI : tlsch_pkg::PH_EXT_SKIP;
            end
            default: begin
            end
         endcase

         // Once the current extension is used up, move to the next header.
         if (in_ext && ext_in == 16'd0) begin
            if (exts_in >= 16'd4) begin
               phase_in = tlsch_pkg::PH_EXT_T_HI;
            end else if (exts_in != 16'd0) begin
               ext_in   = exts_in;
               phase_in = tlsch_pkg::PH_EXT_SKIP;
            end else begin
               phase_in = tlsch_pkg::PH_TRAIL;
            end
         end

         if (err != tlsch_pkg::CAUSE_NONE) begin
            end_v = 1'b1;
            end_r.token_kind  = tlsch_pkg::TK_ERROR;
            end_r.error_cause = err;
            end_r.run_last    = 1'b1;
            failed_in = 1'b1;
            do_reset  = item.last_byte;
         end else if (item.last_byte) begin
            end_v = 1'b1;
            end_r.run_last = 1'b1;
            if (phase_in == tlsch_pkg::PH_EXT_LEN_HI || phase_in == tlsch_pkg::PH_TRAIL) begin
               end_r.token_kind = tlsch_pkg::TK_DONE;
            end else begin
               end_r.token_kind  = tlsch_pkg::TK_ERROR;
               end_r.error_cause = tlsch_pkg::CAUSE_TRUNC;
            end
            do_reset = 1'b1;
         end
      end

      if (do_reset) begin
         phase_in  = tlsch_pkg::PH_VER_HI;
         prefix_in = 6'd0;
         field_in  = 16'd0;
         exts_in   = 16'd0;
         ext_in    = 16'd0;
         list_in   = 16'd0;
         held_in   = 8'd0;
         cls_in    = tlsch_pkg::CLS_OTHER;
         failed_in = 1'b0;
      end
   end

   always_comb begin
      burst = '0;
      if (tok_v) begin
         burst.first.token_kind  = tok_k;
         burst.first.token_value = tok_val;
         burst.first.run_last    = !end_v;
         burst.second            = end_r;
         burst.count             = end_v ? 2'd2 : 2'd1;
      end else if (end_v) begin
         burst.first = end_r;
         burst.count = 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= tlsch_pkg::PH_VER_HI;
         prefix_ff <= 6'd0;
         field_ff  <= 16'd0;
         exts_ff   <= 16'd0;
         ext_ff    <= 16'd0;
         list_ff   <= 16'd0;
         held_ff   <= 8'd0;
         cls_ff    <= tlsch_pkg::CLS_OTHER;
         failed_ff <= 1'b0;
      end else if (step) begin
         phase_ff  <= phase_in;
         prefix_ff <= prefix_in;
         field_ff  <= field_in;
         exts_ff   <= exts_in;
         ext_ff    <= ext_in;
         list_ff   <= list_in;
         held_ff   <= held_in;
         cls_ff    <= cls_in;
         failed_ff <= failed_in;
      end
   end

endmodule
`default_nettype wire

[src/tls_client_hello_token_parser_unit.sv]
`default_nettype none
// Channel   Direction  Beat payload
// req_      in         data_byte, last_byte
// rsp_      out        token_kind, token_value, error_cause, run_last
//
// Each input beat is parsed in the cycle it is accepted and yields zero to two
// result beats, held in a two-entry output buffer and offered from the next cycle.
// One byte enters per cycle while the buffer drains in the same cycle. Reset is
// synchronous and returns the parser to the version byte. A stalled result beat
// holds, and the input stalls whenever a result beat would still be waiting after
// this cycle's output.
module tls_client_hello_token_parser_unit (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   input  tlsch_pkg::req_type   req_payload,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output tlsch_pkg::rsp_type   rsp_payload
);

   tlsch_pkg::burst_type burst;
   tlsch_pkg::rsp_type   buf_ff [2];
   tlsch_pkg::rsp_type   buf_in [2];
   logic [1:0]           cnt_ff, cnt_in;
   logic                 step;
   logic                 pop;
   logic [1:0]           keep;

   assign pop       = (cnt_ff != 2'd0) && !rsp_stall;
   assign keep      = cnt_ff - {1'b0, pop};
   assign req_stall = keep != 2'd0;
   assign step      = req_valid && !req_stall;
   assign rsp_valid = cnt_ff != 2'd0;
   assign rsp_payload = buf_ff[0];

   tlsch_parser u_parser (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .item  (req_payload),
      .burst (burst)
   );

   always_comb begin
      buf_in[0] = buf_ff[0];
      buf_in[1] = buf_ff[1];
      cnt_in    = keep;
      if (pop) begin
         buf_in[0] = buf_ff[1];
      end
      if (step) begin
         // Buffer is empty after this cycle's pop whenever a beat is accepted.
         buf_in[0] = burst.first;
         buf_in[1] = burst.second;
         cnt_in    = burst.count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      buf_ff[0] <= buf_in[0];
      buf_ff[1] <= buf_in[1];
   end

endmodule
`default_nettype wire
